/* rtl/core/pareto_strength_fitness_macros.svh */
`ifndef PARETO_STRENGTH_FITNESS_MACROS_SVH
`define PARETO_STRENGTH_FITNESS_MACROS_SVH

// Property that must hold at every edge outside reset.
`define PSF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PSF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/psf_pkg.sv */
package psf_pkg;

   localparam int POP_MAX   = 64;
   localparam int OBJ_MAX   = 4;
   localparam int OBJ_BITS  = 17;
   localparam int IN_FIELDS = 4;

   localparam int IDX_BITS  = $clog2(POP_MAX);
   localparam int CNT_BITS  = $clog2(POP_MAX + 1);
   localparam int STR_BITS  = $clog2(POP_MAX);
   localparam int FIT_BITS  = 12;
   localparam int OCNT_BITS = 3;

   typedef logic [OBJ_MAX-1:0][OBJ_BITS-1:0] obj_vec_type;

   typedef struct packed {
      logic                valid;
      obj_vec_type         obj;
      logic [STR_BITS-1:0] strength;
   } trav_type;

   typedef struct packed {
      logic load;
      logic own_valid;
      logic rank_start;
      logic rank_step;
      logic sum_start;
      logic sum_step;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RANK,
      ST_SUM,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/psf_cell.sv */
module psf_cell (
   input  logic                          clock,
   input  psf_pkg::cell_ctrl_type        ctrl,
   input  logic [psf_pkg::OCNT_BITS-1:0] used,
   input  psf_pkg::obj_vec_type          load_obj,
   input  psf_pkg::trav_type             trav_in,
   output psf_pkg::trav_type             trav_out,
   input  logic [psf_pkg::FIT_BITS-1:0]  fit_in,
   output logic [psf_pkg::FIT_BITS-1:0]  fit_out
);
   import psf_pkg::*;

   obj_vec_type         own_obj_ff;
   trav_type            trav_ff;
   logic [STR_BITS-1:0] strength_ff;
   logic [FIT_BITS-1:0] fitness_ff;
   obj_vec_type         cmp_a;
   obj_vec_type         cmp_b;
   logic                beats;

   function automatic logic dominates(obj_vec_type a, obj_vec_type b,
                                      logic [OCNT_BITS-1:0] n_used);
      logic le;
      logic ne;
      le = 1'b1;
      ne = 1'b0;
      for (int k = 0; k < OBJ_MAX; k++) begin
         if (OCNT_BITS'(k) < n_used) begin
            if (a[k] > b[k]) le = 1'b0;
            if (a[k] != b[k]) ne = 1'b1;
         end
      end
      return le && ne;
   endfunction

   // rank pass: own against passing; sum pass: passing against own
   always_comb begin
      cmp_a = ctrl.sum_step ? trav_ff.obj : own_obj_ff;
      cmp_b = ctrl.sum_step ? own_obj_ff : trav_ff.obj;
      beats = trav_ff.valid && dominates(cmp_a, cmp_b, used);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         own_obj_ff <= load_obj;
      end
      if (ctrl.rank_start || ctrl.sum_start) begin
         trav_ff.valid    <= ctrl.own_valid;
         trav_ff.obj      <= own_obj_ff;
         trav_ff.strength <= strength_ff;
      end else if (ctrl.rank_step || ctrl.sum_step) begin
         trav_ff <= trav_in;
      end
      if (ctrl.rank_start) begin
         strength_ff <= '0;
      end else if (ctrl.rank_step && beats) begin
         strength_ff <= strength_ff + STR_BITS'(1);
      end
      if (ctrl.sum_start) begin
         fitness_ff <= '0;
      end else if (ctrl.sum_step && beats) begin
         fitness_ff <= fitness_ff + FIT_BITS'(trav_ff.strength);
      end else if (ctrl.shift) begin
         fitness_ff <= fit_in;
      end
   end

   assign trav_out = trav_ff;
   assign fit_out  = fitness_ff;

endmodule

/* rtl/core/pareto_strength_fitness.sv */
// Loads a population one request per cycle, while req_stall is low, into a ring of 64 cells,
// each cell holding one individual's four 17-bit objectives (smaller is better). A request
// with final_item set (stored, or dropped when 64 are already held, which sets
// capacity_overflow) starts the ranking: the objective vectors circulate once round the ring
// so that each cell counts how many individuals it dominates, then circulate again with
// those strengths so that each cell sums the strengths of its dominators. Results then leave
// in load order, one per cycle unless stalled, and the next population can be loaded once
// the last result is in the output register. req_stall is high from the final request until
// then. objective_count is taken as 1 when written 0 and as 4 above 4; write it only while
// the block is idle.
`include "pareto_strength_fitness_macros.svh"

module pareto_strength_fitness (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [psf_pkg::OCNT_BITS-1:0] csr_objective_count,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [psf_pkg::OBJ_BITS-1:0]  req_objective_a,
   input  logic [psf_pkg::OBJ_BITS-1:0]  req_objective_b,
   input  logic [psf_pkg::OBJ_BITS-1:0]  req_objective_c,
   input  logic [psf_pkg::OBJ_BITS-1:0]  req_objective_d,
   input  logic                          req_final_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [5:0]                    rsp_item_index,
   output logic [psf_pkg::FIT_BITS-1:0]  rsp_raw_fitness,
   output logic                          rsp_nondominated,
   output logic                          rsp_capacity_overflow,
   output logic                          rsp_final_result
);
   import psf_pkg::*;

   localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(POP_MAX);

   state_type             state_ff,     state_in;
   logic [CNT_BITS-1:0]   step_ff,      step_in;
   logic [CNT_BITS-1:0]   count_ff,     count_in;
   logic                  overflow_ff,  overflow_in;
   logic [CNT_BITS-1:0]   emit_cnt_ff,  emit_cnt_in;
   logic [OCNT_BITS-1:0]  obj_count_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]            rsp_index_ff, rsp_index_in;
   logic [FIT_BITS-1:0]   rsp_fit_ff,   rsp_fit_in;
   logic                  rsp_ovf_ff,   rsp_ovf_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic                  req_take;
   logic                  out_free;
   logic                  emit_last;
   logic                  rank_start, rank_step, sum_start, sum_step, shift;
   logic [OCNT_BITS-1:0]  used;
   obj_vec_type           load_obj;
   cell_ctrl_type         ctrl [POP_MAX];
   trav_type              trav [POP_MAX];
   logic [FIT_BITS-1:0]   fit  [POP_MAX];

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = (emit_cnt_ff + CNT_BITS'(1)) == count_ff;

   always_comb begin
      if (obj_count_ff == '0) begin
         used = OCNT_BITS'(1);
      end else if (int'(obj_count_ff) > OBJ_MAX) begin
         used = OCNT_BITS'(OBJ_MAX);
      end else begin
         used = obj_count_ff;
      end
   end

   always_comb begin
      load_obj    = '0;
      load_obj[0] = req_objective_a;
      load_obj[1] = req_objective_b;
      load_obj[2] = req_objective_c;
      load_obj[3] = req_objective_d;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_fit_in   = rsp_fit_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      rank_start   = 1'b0;
      rank_step    = 1'b0;
      sum_start    = 1'b0;
      sum_step     = 1'b0;
      shift        = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < CNT_BITS'(POP_MAX)) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_final_item) begin
                  state_in = ST_RANK;
                  step_in  = '0;
               end
            end
         end
         ST_RANK: begin
            rank_start = (step_ff == '0);
            rank_step  = !rank_start;
            step_in    = step_ff + CNT_BITS'(1);
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_start = (step_ff == '0);
            sum_step  = !sum_start;
            step_in   = step_ff + CNT_BITS'(1);
            if (step_ff == STEP_LAST) begin
               step_in     = '0;
               emit_cnt_in = '0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               shift        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_index_in = emit_cnt_ff[5:0];
               rsp_fit_in   = fit[0];
               rsp_ovf_in   = overflow_ff;
               rsp_last_in  = emit_last;
               emit_cnt_in  = emit_cnt_ff + CNT_BITS'(1);
               if (emit_last) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  emit_cnt_in = '0;
                  state_in    = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < POP_MAX; i++) begin
         ctrl[i].load       = req_take && (count_ff < CNT_BITS'(POP_MAX)) &&
                              (count_ff[IDX_BITS-1:0] == IDX_BITS'(i));
         ctrl[i].own_valid  = CNT_BITS'(i) < count_ff;
         ctrl[i].rank_start = rank_start;
         ctrl[i].rank_step  = rank_step;
         ctrl[i].sum_start  = sum_start;
         ctrl[i].sum_step   = sum_step;
         ctrl[i].shift      = shift;
      end
   end

   for (genvar i = 0; i < POP_MAX; i++) begin : g_cell
      localparam int PREV = (i + POP_MAX - 1) % POP_MAX;
      localparam int NEXT = (i + 1) % POP_MAX;
      psf_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl[i]),
         .used     (used),
         .load_obj (load_obj),
         .trav_in  (trav[PREV]),
         .trav_out (trav[i]),
         .fit_in   ((i == POP_MAX - 1) ? '0 : fit[NEXT]),
         .fit_out  (fit[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         emit_cnt_ff  <= '0;
         obj_count_ff <= OCNT_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            obj_count_ff <= csr_objective_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_fit_ff   <= rsp_fit_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_item_index        = rsp_index_ff;
   assign rsp_raw_fitness       = rsp_fit_ff;
   assign rsp_nondominated      = (rsp_fit_ff == '0);
   assign rsp_capacity_overflow = rsp_ovf_ff;
   assign rsp_final_result      = rsp_last_ff;

   `PSF_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_BITS'(POP_MAX), "loaded count beyond capacity")
   `PSF_ASSERT(a_step_bound, clock, reset, step_ff <= STEP_LAST, "ring step beyond ring length")
   `PSF_ASSERT_NEXT(a_final_starts, clock, reset, req_take && req_final_item, state_ff == ST_RANK, "final request did not start ranking")
   `PSF_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_valid && !rsp_stall && !rsp_final_result, rsp_valid, "gap inside result burst")

endmodule
